[hw/rtl/sat_pkg.sv]
// shared types, constants and helpers of the sorted alarm timer queue
package sat_pkg;

	localparam int QUEUE_DEPTH = 16;

	localparam logic [1:0] RES_ACCEPT  = 2'd0;
	localparam logic [1:0] RES_REJECT  = 2'd1;
	localparam logic [1:0] RES_EXPIRED = 2'd2;

	localparam logic KIND_TICK   = 1'b0;
	localparam logic KIND_INSERT = 1'b1;

	typedef struct packed {
		logic        kind;
		logic [15:0] delay_seconds;
		logic [7:0]  tag;
	} in_t;

	typedef struct packed {
		logic [1:0]  event_res;
		logic [7:0]  tag_out;
		logic [15:0] delay_out;
		logic        last;
	} out_t;

	typedef struct packed {
		logic        valid;
		logic [31:0] expiry;
		logic [7:0]  tag;
		logic [15:0] delay;
	} entry_t;

	typedef enum logic [1:0] {
		OP_HOLD,
		OP_INSERT,
		OP_SHIFT
	} cell_op_t;

	typedef struct packed {
		cell_op_t    op;
		logic [31:0] expiry;
		logic [7:0]  tag;
		logic [15:0] delay;
	} cell_ctl_t;

	typedef enum logic {
		ST_IDLE,
		ST_POP
	} state_t;

	// a at or before b, modulo 2^32
	function automatic logic at_or_before(input logic [31:0] a, input logic [31:0] b);
		logic [31:0] diff;
		diff = b - a;
		return ~diff[31];
	endfunction

endpackage

[hw/rtl/sat_cell.sv]
// one slot of the sorted alarm chain
module sat_cell import sat_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  cell_ctl_t ctl,
	input  entry_t    prev_entry,
	input  logic      prev_hit,
	input  entry_t    next_entry,
	output entry_t    entry,
	output logic      hit
);

	logic        valid_q;
	logic [31:0] expiry_q;
	logic [7:0]  tag_q;
	logic [15:0] delay_q;

	assign entry = '{valid: valid_q, expiry: expiry_q, tag: tag_q, delay: delay_q};

	// new alarm belongs at or before this slot
	assign hit = ~valid_q | at_or_before(ctl.expiry, expiry_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else begin
			case (ctl.op)
				OP_INSERT: begin
					if (hit) begin
						valid_q <= prev_hit ? prev_entry.valid : 1'b1;
					end
				end
				OP_SHIFT: begin
					valid_q <= next_entry.valid;
				end
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (ctl.op)
			OP_INSERT: begin
				if (hit) begin
					if (prev_hit) begin
						expiry_q <= prev_entry.expiry;
						tag_q    <= prev_entry.tag;
						delay_q  <= prev_entry.delay;
					end else begin
						expiry_q <= ctl.expiry;
						tag_q    <= ctl.tag;
						delay_q  <= ctl.delay;
					end
				end
			end
			OP_SHIFT: begin
				expiry_q <= next_entry.expiry;
				tag_q    <= next_entry.tag;
				delay_q  <= next_entry.delay;
			end
			default: begin
			end
		endcase
	end

endmodule

[hw/rtl/sorted_alarm_timer_queue_top.sv]
// top level of the sorted alarm timer queue: cell chain, sequencer and output register
// Holds up to QUEUE_DEPTH alarms in a chain of cells kept sorted by expiry,
// newest first among equal expiries, plus a 32-bit seconds counter. An insert
// word is placed with every cell deciding from its neighbor alone, and is
// answered with one accepted or rejected word in the next cycle. A tick word
// bumps the time, then pops the head of the chain once per due alarm,
// shifting the whole chain by one cell each pop and waiting while the output
// is stalled. One word is in work at a time; the next is taken once the
// sequencer is idle and the output register is free or being drained.
module sorted_alarm_timer_queue_top import sat_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic in_valid,
	output logic in_ready,
	input  in_t  in_data,
	output logic out_valid,
	input  logic out_ready,
	output out_t out_data
);

	state_t      state_q, state_d;
	logic [31:0] time_q;
	logic        out_valid_q;
	out_t        out_data_q, out_data_d;
	logic        load_out;
	logic        out_free;
	logic        take_in;
	logic        head_due, next_due, full;
	cell_ctl_t   ctl;
	cell_op_t    op;

	entry_t      cell_entry [QUEUE_DEPTH];
	logic        cell_hit   [QUEUE_DEPTH];

	genvar gi;
	generate
		for (gi = 0; gi < QUEUE_DEPTH; gi++) begin : g_cell
			entry_t prev_e, next_e;
			logic   prev_h;
			if (gi == 0) begin : g_first
				assign prev_e = '0;
				assign prev_h = 1'b0;
			end else begin : g_mid
				assign prev_e = cell_entry[gi-1];
				assign prev_h = cell_hit[gi-1];
			end
			if (gi == QUEUE_DEPTH - 1) begin : g_end
				assign next_e = '0;
			end else begin : g_more
				assign next_e = cell_entry[gi+1];
			end
			sat_cell u_cell (
				.clk        (clk),
				.arst_n     (arst_n),
				.ctl        (ctl),
				.prev_entry (prev_e),
				.prev_hit   (prev_h),
				.next_entry (next_e),
				.entry      (cell_entry[gi]),
				.hit        (cell_hit[gi])
			);
			if (gi == 1) begin : g_next_due
				assign next_due = cell_entry[1].valid
					& at_or_before(cell_entry[1].expiry, time_q);
			end
		end
		if (QUEUE_DEPTH == 1) begin : g_single
			assign next_due = 1'b0;
		end
	endgenerate

	assign full     = cell_entry[QUEUE_DEPTH-1].valid;
	assign head_due = cell_entry[0].valid & at_or_before(cell_entry[0].expiry, time_q);
	assign out_free = ~out_valid_q | out_ready;
	assign in_ready = (state_q == ST_IDLE) & out_free;
	assign take_in  = in_valid & in_ready;

	assign ctl = '{op: op, expiry: time_q + {16'd0, in_data.delay_seconds},
		tag: in_data.tag, delay: in_data.delay_seconds};

	always_comb begin
		state_d    = state_q;
		op         = OP_HOLD;
		load_out   = 1'b0;
		out_data_d = out_data_q;
		case (state_q)
			ST_IDLE: begin
				if (take_in) begin
					if (in_data.kind == KIND_INSERT) begin
						load_out   = 1'b1;
						out_data_d = '{event_res: full ? RES_REJECT : RES_ACCEPT,
							tag_out: in_data.tag, delay_out: in_data.delay_seconds,
							last: 1'b1};
						if (!full) begin
							op = OP_INSERT;
						end
					end else begin
						state_d = ST_POP;
					end
				end
			end
			ST_POP: begin
				if (!head_due) begin
					state_d = ST_IDLE;
				end else if (out_free) begin
					load_out   = 1'b1;
					op         = OP_SHIFT;
					out_data_d = '{event_res: RES_EXPIRED, tag_out: cell_entry[0].tag,
						delay_out: cell_entry[0].delay, last: ~next_due};
					if (!next_due) begin
						state_d = ST_IDLE;
					end
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			time_q      <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (take_in && in_data.kind == KIND_TICK) begin
				time_q <= time_q + 32'd1;
			end
			if (load_out) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load_out) begin
			out_data_q <= out_data_d;
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_data_q;

endmodule

[hw/rtl/sat_checker.sv]
// port-level checks of the sorted alarm timer queue, bound to the top level
module sat_checker import sat_pkg::*; (
	input logic clk,
	input logic arst_n,
	input logic in_valid,
	input logic in_ready,
	input in_t  in_data,
	input logic out_valid,
	input logic out_ready,
	input out_t out_data
);

	// stalled output word holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(out_data))
		else $error("output word changed while stalled");

	// insert answers are single words
	a_insert_last: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_data.event_res != RES_EXPIRED |-> out_data.last)
		else $error("insert answer without last");

	a_res_code: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> out_data.event_res == RES_ACCEPT
			|| out_data.event_res == RES_REJECT
			|| out_data.event_res == RES_EXPIRED)
		else $error("bad result code");

	// an accepted insert is answered in the next cycle with its own tag
	a_insert_answer: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready && in_data.kind == KIND_INSERT |=>
			out_valid && out_data.event_res != RES_EXPIRED
			&& out_data.tag_out == $past(in_data.tag)
			&& out_data.delay_out == $past(in_data.delay_seconds))
		else $error("insert not answered");

	// no new word taken while an expiry burst is unfinished
	a_no_take_mid_burst: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_data.event_res == RES_EXPIRED && !out_data.last |-> !in_ready)
		else $error("input taken during expiry burst");

endmodule

bind sorted_alarm_timer_queue_top sat_checker u_sat_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_valid  (in_valid),
	.in_ready  (in_ready),
	.in_data   (in_data),
	.out_valid (out_valid),
	.out_ready (out_ready),
	.out_data  (out_data)
);

[tb/tb_sorted_alarm_timer_queue_top.sv]
// testbench of the sorted alarm timer queue: directed table, random alarms and ticks, scoreboard
`timescale 1ns / 100ps

module tb_sorted_alarm_timer_queue_top;
	import sat_pkg::*;

	localparam int MAX_EXPIRED  = 16;
	localparam int RANDOM_WORDS = 346;
	localparam int CALM_WORDS   = 40;
	localparam int DRAIN_CYCLES = 64;
	localparam int CYCLE_LIMIT  = 400000;
	localparam int PRINT_LIMIT  = 40;

	typedef struct {
		in_t  w;
		bit   typed;
		bit   has_res;
		out_t res;
	} row_t;

	logic clk;
	logic arst_n;
	logic in_valid;
	logic in_ready;
	in_t  in_data;
	logic out_valid;
	logic out_ready;
	out_t out_data;

	// alarm list as the block should hold it
	logic [31:0] now_sec;
	logic [31:0] alarm_expiry [QUEUE_DEPTH];
	logic [7:0]  alarm_label [QUEUE_DEPTH];
	logic [15:0] alarm_delay [QUEUE_DEPTH];
	int          alarm_count;

	out_t due_words [$];
	row_t table_rows [$];
	bit   idle_on = 1'b1;
	int   fault_count = 0;
	int   cycles = 0;
	int   sent_words = 0;
	int   n_accept = 0;
	int   n_reject = 0;
	int   n_expired = 0;

	sorted_alarm_timer_queue_top dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.in_data   (in_data),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_data  (out_data)
	);

	always begin
		clk = 1'b1;
		#4;
		clk = 1'b0;
		#4;
	end

	function automatic in_t make_word(input logic k, input logic [15:0] d, input logic [7:0] t);
		return {k, d, t};
	endfunction

	function automatic out_t make_result(input logic [1:0] r, input logic [7:0] t,
		input logic [15:0] d, input logic l);
		return {r, t, d, l};
	endfunction

	// a is at or before b on the wrapping seconds scale
	function automatic bit not_later(input logic [31:0] a, input logic [31:0] b);
		return (b - a) < 32'h8000_0000;
	endfunction

	task automatic add_row(input in_t w, input bit typed, input bit has_res, input out_t res);
		row_t r;
		r.w = w;
		r.typed = typed;
		r.has_res = has_res;
		r.res = res;
		table_rows.push_back(r);
	endtask

	task automatic advance_alarms(input in_t w, input bit record);
		logic [31:0] due;
		int slot;
		int n;
		int i;
		if (w.kind == KIND_INSERT) begin
			if (alarm_count >= QUEUE_DEPTH) begin
				if (record)
					due_words.push_back(make_result(RES_REJECT, w.tag, w.delay_seconds, 1'b1));
			end else begin
				due = now_sec + 32'(w.delay_seconds);
				slot = alarm_count;
				for (i = 0; i < alarm_count; i++) begin
					if (not_later(due, alarm_expiry[i])) begin
						slot = i;
						break;
					end
				end
				for (i = alarm_count; i > slot; i--) begin
					alarm_expiry[i] = alarm_expiry[i - 1];
					alarm_label[i]  = alarm_label[i - 1];
					alarm_delay[i]  = alarm_delay[i - 1];
				end
				alarm_expiry[slot] = due;
				alarm_label[slot]  = w.tag;
				alarm_delay[slot]  = w.delay_seconds;
				alarm_count++;
				if (record)
					due_words.push_back(make_result(RES_ACCEPT, w.tag, w.delay_seconds, 1'b1));
			end
		end else begin
			now_sec = now_sec + 32'd1;
			n = 0;
			while (n < alarm_count && n < MAX_EXPIRED && not_later(alarm_expiry[n], now_sec))
				n++;
			if (record) begin
				for (i = 0; i < n; i++)
					due_words.push_back(make_result(RES_EXPIRED, alarm_label[i], alarm_delay[i],
						i == n - 1));
			end
			for (i = n; i < alarm_count; i++) begin
				alarm_expiry[i - n] = alarm_expiry[i];
				alarm_label[i - n]  = alarm_label[i];
				alarm_delay[i - n]  = alarm_delay[i];
			end
			alarm_count -= n;
		end
	endtask

	task automatic send_word(input in_t w);
		if (idle_on && $urandom_range(0, 3) == 0) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 15)) @(posedge clk);
		end
		in_data  <= w;
		in_valid <= 1'b1;
		do @(posedge clk); while (in_ready !== 1'b1);
		sent_words++;
	endtask

	task automatic check_field(input string name, input logic [31:0] want, input logic [31:0] got);
		if (got !== want) begin
			fault_count++;
			if (fault_count <= PRINT_LIMIT)
				$display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
		end
	endtask

	// receiver stalls
	always begin
		@(posedge clk);
		if (idle_on && $urandom_range(0, 2) == 0) begin
			out_ready <= 1'b0;
			repeat ($urandom_range(1, 15)) @(posedge clk);
		end
		out_ready <= 1'b1;
		repeat ($urandom_range(1, 20)) @(posedge clk);
	end

	always @(posedge clk) begin
		out_t want;
		if (arst_n === 1'b1 && out_valid === 1'b1 && out_ready === 1'b1) begin
			case (out_data.event_res)
				RES_ACCEPT:  n_accept++;
				RES_REJECT:  n_reject++;
				RES_EXPIRED: n_expired++;
				default: ;
			endcase
			if (due_words.size() == 0) begin
				fault_count++;
				if (fault_count <= PRINT_LIMIT)
					$display("%0t: result word with none expected, expected nothing, actual %h",
						$time, out_data);
			end else begin
				want = due_words.pop_front();
				check_field("event_res", want.event_res, out_data.event_res);
				check_field("tag_out", want.tag_out, out_data.tag_out);
				check_field("delay_out", want.delay_out, out_data.delay_out);
				check_field("last", want.last, out_data.last);
			end
		end
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles >= CYCLE_LIMIT) begin
			$display("run stopped after %0d cycles with %0d results outstanding", cycles,
				due_words.size());
			$display("Testbench completed WITH ERRORS");
			$finish;
		end
	end

	initial begin
		in_t w;
		int i;
		int pct;
		logic [15:0] d;
		arst_n = 1'b0;
		in_valid = 1'b0;
		in_data = '0;
		out_ready = 1'b0;
		now_sec = '0;
		alarm_count = 0;

		// tick on an empty list, then two zero-delay alarms with the same expiry
		add_row(make_word(KIND_TICK, 16'h0000, 8'h00), 1'b1, 1'b0, '0);
		add_row(make_word(KIND_INSERT, 16'h0000, 8'h00), 1'b1, 1'b1,
			make_result(RES_ACCEPT, 8'h00, 16'h0000, 1'b1));
		add_row(make_word(KIND_INSERT, 16'h0000, 8'hFF), 1'b1, 1'b1,
			make_result(RES_ACCEPT, 8'hFF, 16'h0000, 1'b1));
		add_row(make_word(KIND_TICK, 16'hFFFF, 8'hFF), 1'b0, 1'b0, '0);
		// fill the list with alarms all due on the same second
		for (i = 0; i < QUEUE_DEPTH; i++)
			add_row(make_word(KIND_INSERT, 16'd1, 8'(i * 17)), 1'b1, 1'b1,
				make_result(RES_ACCEPT, 8'(i * 17), 16'd1, 1'b1));
		add_row(make_word(KIND_INSERT, 16'hFFFF, 8'hFF), 1'b1, 1'b1,
			make_result(RES_REJECT, 8'hFF, 16'hFFFF, 1'b1));
		add_row(make_word(KIND_INSERT, 16'h0000, 8'h00), 1'b1, 1'b1,
			make_result(RES_REJECT, 8'h00, 16'h0000, 1'b1));
		// full burst of expiries, then nothing left
		add_row(make_word(KIND_TICK, 16'h0000, 8'h00), 1'b0, 1'b0, '0);
		add_row(make_word(KIND_TICK, 16'h0000, 8'h00), 1'b1, 1'b0, '0);

		repeat (4) @(posedge clk);
		arst_n <= 1'b1;

		foreach (table_rows[i]) begin
			send_word(table_rows[i].w);
			if (table_rows[i].typed) begin
				advance_alarms(table_rows[i].w, 1'b0);
				if (table_rows[i].has_res)
					due_words.push_back(table_rows[i].res);
			end else begin
				advance_alarms(table_rows[i].w, 1'b1);
			end
		end

		for (i = 0; i < RANDOM_WORDS; i++) begin
			if (i == RANDOM_WORDS - CALM_WORDS)
				idle_on = 1'b0;
			// alternate filling, draining and balanced stretches
			case ((i / 40) % 3)
				0: pct = 75;
				1: pct = 30;
				default: pct = 55;
			endcase
			if ($urandom_range(0, 99) < pct) begin
				if (alarm_count >= QUEUE_DEPTH || $urandom_range(0, 49) == 0)
					d = 16'($urandom_range(0, 65535));
				else if ($urandom_range(0, 3) == 0)
					d = 16'($urandom_range(16, 120));
				else
					d = 16'($urandom_range(0, 15));
				w = make_word(KIND_INSERT, d, 8'($urandom_range(0, 255)));
			end else begin
				w = make_word(KIND_TICK, 16'($urandom_range(0, 65535)), 8'($urandom_range(0, 255)));
			end
			send_word(w);
			advance_alarms(w, 1'b1);
		end
		in_valid <= 1'b0;

		while (due_words.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		$display("%0d words sent (%0d from the table), %0d alarms accepted, %0d rejected as full",
			sent_words, table_rows.size(), n_accept, n_reject);
		$display("%0d alarms expired, %0d left pending, %0d mismatches", n_expired, alarm_count,
			fault_count);
		if (fault_count == 0)
			$display("Testbench completed without errors");
		else
			$display("Testbench completed WITH ERRORS");
		$finish;
	end

endmodule
